// ----- src/rvm_pkg.sv -----
// Shared types, constants and register codes of the resampling voice mixer.
// No dependencies; every other file of the block but rvm_front refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package rvm_pkg;

	// default parameter values
	localparam int PHASE_FRAC_BITS_DEF = 16;
	localparam int SAMPLE_BITS_DEF     = 16;
	localparam int SPEAKERS_DEF        = 8;

	// fixed field widths of the register set
	localparam int RATE_W     = 18;
	localparam int START_W    = 16;
	localparam int MODE_W     = 3;
	localparam int GAINS_W    = 64;
	localparam int GAIN_W     = 16;
	localparam int GAIN_FRAC  = 14;
	localparam int SPK_PORTS  = 8;

	// smallest rate step is one frame shifted right by this amount
	localparam int STEP_MIN_SHIFT = 6;

	// mix_mode bits
	localparam int MODE_STEREO   = 0;
	localparam int MODE_SURROUND = 1;
	localparam int MODE_INVERT   = 2;

	// APB register map, 8 bytes per register
	localparam int ADDR_W   = 6;
	localparam int DATA_W   = 64;
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_RATE_STEP   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_START_PHASE = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MIX_MODE    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_GAINS_FRONT = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_GAINS_REAR  = 3'd4;
	localparam logic [RATE_W-1:0]    RATE_STEP_RST   = 18'd65536;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [RATE_W-1:0]  rate_step;
		logic [START_W-1:0] start_phase;
		logic [MODE_W-1:0]  mix_mode;
		logic [GAINS_W-1:0] gains_front;
		logic [GAINS_W-1:0] gains_rear;
	} cfg_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} q_stat_t;

	typedef struct packed {
		logic run;
		logic phase_in_frame;
	} bk_stat_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} bk_state_t;

endpackage

`default_nettype wire

// ----- src/rvm_front.sv -----
// Front end: accepts source frames, pairs each with the previous frame and
// marks the priming frame. Does not depend on rvm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rvm_front #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0] src_left,
	input  wire logic signed [SAMPLE_BITS-1:0] src_right,
	input  wire logic                         q_full,
	output logic                              q_push,
	output logic [4*SAMPLE_BITS:0]            q_wdata
);

	logic                   primed_q;
	logic [SAMPLE_BITS-1:0] prev_l_q;
	logic [SAMPLE_BITS-1:0] prev_r_q;

	// stall while the queue has no room
	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	// entry: prime flag, previous frame, new frame
	assign q_wdata = {!primed_q, prev_r_q, prev_l_q, src_right, src_left};

	// remember that a frame was seen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
		end else if (q_push) begin
			primed_q <= 1'b1;
		end
	end

	// hold the previous frame; it reads as zero before priming
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_l_q <= '0;
			prev_r_q <= '0;
		end else if (q_push) begin
			prev_l_q <= src_left;
			prev_r_q <= src_right;
		end
	end

endmodule

`default_nettype wire

// ----- src/rvm_queue.sv -----
// Short register queue that decouples the front end from the back end.
// Depends on rvm_pkg for depth, pointer widths and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module rvm_queue #(
	parameter int WIDTH = 65
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output rvm_pkg::q_stat_t      stat
);

	logic [WIDTH-1:0]          mem_q [rvm_pkg::QUEUE_DEPTH];
	logic [rvm_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [rvm_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [rvm_pkg::QCNT_W-1:0] count_q;
	logic                      do_push;
	logic                      do_pop;

	assign stat.full  = (count_q == rvm_pkg::QCNT_W'(rvm_pkg::QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.count = count_q;

	// drop a push into a full queue and a pop from an empty one
	assign do_push = push && !stat.full;
	assign do_pop  = pop && !stat.empty;

	assign rdata = mem_q[rd_ptr_q];

	// store the entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- src/rvm_back.sv -----
// Back end: phase sequencer plus interpolation and speaker gain pipeline.
// Depends on rvm_pkg for the config struct, state enum and constants.
`timescale 1ns / 1ps
`default_nettype none

module rvm_back #(
	parameter int PHASE_FRAC_BITS = 16,
	parameter int SAMPLE_BITS     = 16,
	parameter int SPEAKERS        = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire rvm_pkg::cfg_t         cfg,
	input  wire logic                  q_empty,
	input  wire logic [4*SAMPLE_BITS:0] q_rdata,
	output logic                       q_pop,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic signed [SAMPLE_BITS+1:0] spk [rvm_pkg::SPK_PORTS],
	output logic                       out_last,
	output rvm_pkg::bk_stat_t          stat
);

	localparam int FB = PHASE_FRAC_BITS;
	localparam int SB = SAMPLE_BITS;
	localparam int OB = SB + 2;
	localparam int PHASE_W = ((FB > rvm_pkg::RATE_W) ? FB : rvm_pkg::RATE_W) + 1;
	localparam int PW  = SB + FB + 2;
	localparam int PW1 = PW + 1;
	localparam int GW  = SB + rvm_pkg::GAIN_W + 1;
	localparam int GW1 = GW + 1;
	localparam int QW  = GW1 - rvm_pkg::GAIN_FRAC;
	localparam logic [PHASE_W-1:0] PHASE_ONE = {{(PHASE_W-1){1'b0}}, 1'b1} << FB;
	localparam logic [PHASE_W-1:0] MIN_STEP  = PHASE_ONE >> rvm_pkg::STEP_MIN_SHIFT;
	localparam logic signed [PW:0] HALF = PW1'(1) <<< (FB - 1);
	localparam logic signed [GW:0] GAIN_HALF = GW1'(1) <<< (rvm_pkg::GAIN_FRAC - 1);
	localparam logic signed [OB-1:0] SAT_MAX = {1'b0, {(OB-1){1'b1}}};
	localparam logic signed [OB-1:0] SAT_MIN = {1'b1, {(OB-1){1'b0}}};

	rvm_pkg::bk_state_t state_q, state_d;

	logic [PHASE_W-1:0] phase_q;
	logic [PHASE_W-1:0] step;
	logic [PHASE_W-1:0] step_sum;
	logic [PHASE_W-1:0] start_ld;
	logic [PHASE_W-1:0] rate_ext;
	logic               in_frame;
	logic               last_i;
	logic               issue;
	logic               adv;
	logic               ent_prime;
	logic               stereo;
	logic               surround;
	logic               invert;

	logic signed [SB-1:0] wl_p_q, wr_p_q, wl_n_q, wr_n_q;
	logic [FB:0]          w0;
	logic signed [FB+1:0] w0_s;
	logic signed [FB+1:0] f_s;

	logic                 v_s1, last_s1;
	logic signed [PW-1:0] pl_s1, nl_s1, pr_s1, nr_s1;
	logic                 v_s2, last_s2;
	logic signed [SB-1:0] sl_s2, sr_s2, avg_s2;
	logic signed [PW:0]   sum_l, sum_r;
	logic signed [SB-1:0] sl_c, sr_c;
	logic signed [SB:0]   lr_sum;
	logic                 v_s3, last_s3;
	logic                 out_valid_q, out_last_q;

	assign stereo   = cfg.mix_mode[rvm_pkg::MODE_STEREO];
	assign surround = cfg.mix_mode[rvm_pkg::MODE_SURROUND];
	assign invert   = cfg.mix_mode[rvm_pkg::MODE_INVERT];

	// pipeline moves when the output register is free or being taken
	assign adv = !out_valid_q || !out_stall;

	// clamp the step and form the next phase
	assign rate_ext = {{(PHASE_W-rvm_pkg::RATE_W){1'b0}}, cfg.rate_step};
	assign step     = (rate_ext < MIN_STEP) ? MIN_STEP : rate_ext;
	assign step_sum = phase_q + step;
	assign last_i   = (step_sum >= PHASE_ONE);
	assign in_frame = (phase_q < PHASE_ONE);
	assign start_ld = {{(PHASE_W-rvm_pkg::START_W){1'b0}}, cfg.start_phase}
		& (PHASE_ONE - 1'b1);
	assign ent_prime = q_rdata[4*SB];

	assign stat.run            = (state_q == rvm_pkg::BK_RUN);
	assign stat.phase_in_frame = in_frame;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rvm_pkg::BK_IDLE: begin
				if (!q_empty && !ent_prime && in_frame) begin
					state_d = rvm_pkg::BK_RUN;
				end
			end
			rvm_pkg::BK_RUN: begin
				if (adv && last_i) begin
					state_d = rvm_pkg::BK_IDLE;
				end
			end
			default: state_d = rvm_pkg::BK_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		q_pop = 1'b0;
		issue = 1'b0;
		case (state_q)
			rvm_pkg::BK_IDLE: q_pop = !q_empty;
			rvm_pkg::BK_RUN:  issue = adv;
			default: begin
				q_pop = 1'b0;
				issue = 1'b0;
			end
		endcase
	end

	// state and phase accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rvm_pkg::BK_IDLE;
			phase_q <= '0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				if (ent_prime) begin
					phase_q <= start_ld;
				end else if (!in_frame) begin
					phase_q <= phase_q - PHASE_ONE;
				end
			end else if (issue) begin
				phase_q <= last_i ? (step_sum - PHASE_ONE) : step_sum;
			end
		end
	end

	// latch the frame pair of the popped transaction
	always_ff @(posedge clk) begin
		if (q_pop) begin
			wl_n_q <= q_rdata[SB-1:0];
			wr_n_q <= q_rdata[2*SB-1:SB];
			wl_p_q <= q_rdata[3*SB-1:2*SB];
			wr_p_q <= q_rdata[4*SB-1:3*SB];
		end
	end

	// interpolation weights; phase is inside the frame while running
	assign w0   = PHASE_ONE[FB:0] - phase_q[FB:0];
	assign w0_s = $signed({1'b0, w0});
	assign f_s  = $signed({2'b00, phase_q[FB-1:0]});

	// valid bits of the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= issue;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	// stage 1: weight both frames
	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= last_i;
			pl_s1   <= wl_p_q * w0_s;
			nl_s1   <= wl_n_q * f_s;
			pr_s1   <= wr_p_q * w0_s;
			nr_s1   <= wr_n_q * f_s;
		end
	end

	// stage 2: round to sample precision and form the channel average
	assign sum_l  = PW1'(pl_s1) + PW1'(nl_s1) + HALF;
	assign sum_r  = PW1'(pr_s1) + PW1'(nr_s1) + HALF;
	assign sl_c   = sum_l[FB+SB-1:FB];
	assign sr_c   = stereo ? sum_r[FB+SB-1:FB] : sl_c;
	assign lr_sum = {sl_c[SB-1], sl_c} + {sr_c[SB-1], sr_c};

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s2 <= last_s1;
			sl_s2   <= sl_c;
			sr_s2   <= sr_c;
			avg_s2  <= stereo ? lr_sum[SB:1] : sl_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s3    <= last_s2;
			out_last_q <= last_s3;
		end
	end

	// stages 3 and 4: one gain lane per speaker, then round and saturate
	for (genvar k = 0; k < rvm_pkg::SPK_PORTS; k++) begin : g_lane
		if (k < SPEAKERS) begin : g_on
			logic [rvm_pkg::GAINS_W-1:0] gword;
			logic [rvm_pkg::GAIN_W-1:0]  graw;
			logic signed [rvm_pkg::GAIN_W:0] gext;
			logic signed [rvm_pkg::GAIN_W:0] gsel;
			logic signed [SB-1:0]        smp;
			logic signed [GW-1:0]        prod_s3;
			logic signed [GW:0]          rnd;
			logic signed [QW-1:0]        qv;
			logic                        fits;
			logic signed [OB-1:0]        spk_q;

			assign gword = (k < 4) ? cfg.gains_front : cfg.gains_rear;
			assign graw  = gword[rvm_pkg::GAIN_W*(k%4) +: rvm_pkg::GAIN_W];
			assign gext  = $signed({graw[rvm_pkg::GAIN_W-1], graw});

			// route the sample and pick the gain
			always_comb begin
				gsel = gext;
				if ((k == 1) && invert) begin
					gsel = -gext;
				end
				if ((k >= 2) && !surround) begin
					gsel = '0;
				end
			end

			if ((k == 4) || (k == 5)) begin : g_avg
				assign smp = avg_s2;
			end else if ((k % 2) == 1) begin : g_right
				assign smp = sr_s2;
			end else begin : g_left
				assign smp = sl_s2;
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					prod_s3 <= smp * gsel;
				end
			end

			assign rnd  = GW1'(prod_s3) + GAIN_HALF;
			assign qv   = rnd[GW:rvm_pkg::GAIN_FRAC];
			assign fits = (qv[QW-1:OB-1] == {(QW-OB+1){qv[QW-1]}});

			always_ff @(posedge clk) begin
				if (adv) begin
					spk_q <= fits ? qv[OB-1:0] : (qv[QW-1] ? SAT_MIN : SAT_MAX);
				end
			end

			assign spk[k] = spk_q;
		end else begin : g_off
			assign spk[k] = '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

// ----- src/resampling_voice_mixer.sv -----
// Top level of the resampling voice mixer: APB registers, front, queue, back.
// Flow: an accepted source frame enters the queue, is popped into the frame latch
// while the back end is idle, and each output passes the pipeline; stalls hold it.
// The sequencer issues one output per cycle while the output does not stall;
// a priming or skipped frame retires with its pop alone and yields no output.
// Reset: registers take their reset values, the queue empties, the block is unprimed.
`timescale 1ns / 1ps
`default_nettype none

module resampling_voice_mixer #(
	parameter int PHASE_FRAC_BITS = rvm_pkg::PHASE_FRAC_BITS_DEF,
	parameter int SAMPLE_BITS     = rvm_pkg::SAMPLE_BITS_DEF,
	parameter int SPEAKERS        = rvm_pkg::SPEAKERS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [rvm_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [rvm_pkg::DATA_W-1:0]    pwdata,
	output logic [rvm_pkg::DATA_W-1:0]         prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0] src_left,
	input  wire logic signed [SAMPLE_BITS-1:0] src_right,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [SAMPLE_BITS+1:0]      spk_front_left,
	output logic signed [SAMPLE_BITS+1:0]      spk_front_right,
	output logic signed [SAMPLE_BITS+1:0]      spk_rear_left,
	output logic signed [SAMPLE_BITS+1:0]      spk_rear_right,
	output logic signed [SAMPLE_BITS+1:0]      spk_center,
	output logic signed [SAMPLE_BITS+1:0]      spk_lfe,
	output logic signed [SAMPLE_BITS+1:0]      spk_side_left,
	output logic signed [SAMPLE_BITS+1:0]      spk_side_right,
	output logic                               out_last
);

	localparam int ENT_W = 4 * SAMPLE_BITS + 1;

	rvm_pkg::cfg_t     cfg_q;
	rvm_pkg::q_stat_t  q_stat;
	rvm_pkg::bk_stat_t bk_stat;

	logic [rvm_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          cfg_wr;
	logic                          q_push;
	logic                          q_pop;
	logic [ENT_W-1:0]              q_wdata;
	logic [ENT_W-1:0]              q_rdata;
	logic signed [SAMPLE_BITS+1:0] spk [rvm_pkg::SPK_PORTS];

	// register access decode
	assign pready  = 1'b1;
	assign reg_idx = paddr[rvm_pkg::ADDR_W-1:3];
	assign cfg_wr  = psel && penable && pwrite && pready;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_step   <= rvm_pkg::RATE_STEP_RST;
			cfg_q.start_phase <= '0;
			cfg_q.mix_mode    <= '0;
			cfg_q.gains_front <= '0;
			cfg_q.gains_rear  <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				rvm_pkg::REG_RATE_STEP:
					cfg_q.rate_step <= pwdata[rvm_pkg::RATE_W-1:0];
				rvm_pkg::REG_START_PHASE:
					cfg_q.start_phase <= pwdata[rvm_pkg::START_W-1:0];
				rvm_pkg::REG_MIX_MODE:
					cfg_q.mix_mode <= pwdata[rvm_pkg::MODE_W-1:0];
				rvm_pkg::REG_GAINS_FRONT:
					cfg_q.gains_front <= pwdata;
				rvm_pkg::REG_GAINS_REAR:
					cfg_q.gains_rear <= pwdata;
				default: ;
			endcase
		end
	end

	// read back configuration registers
	always_comb begin
		case (reg_idx)
			rvm_pkg::REG_RATE_STEP:   prdata = rvm_pkg::DATA_W'(cfg_q.rate_step);
			rvm_pkg::REG_START_PHASE: prdata = rvm_pkg::DATA_W'(cfg_q.start_phase);
			rvm_pkg::REG_MIX_MODE:    prdata = rvm_pkg::DATA_W'(cfg_q.mix_mode);
			rvm_pkg::REG_GAINS_FRONT: prdata = cfg_q.gains_front;
			rvm_pkg::REG_GAINS_REAR:  prdata = cfg_q.gains_rear;
			default:                  prdata = '0;
		endcase
	end

	rvm_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.src_left (src_left),
		.src_right(src_right),
		.q_full   (q_stat.full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	rvm_queue #(
		.WIDTH(ENT_W)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.pop   (q_pop),
		.rdata (q_rdata),
		.stat  (q_stat)
	);

	rvm_back #(
		.PHASE_FRAC_BITS(PHASE_FRAC_BITS),
		.SAMPLE_BITS    (SAMPLE_BITS),
		.SPEAKERS       (SPEAKERS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_stat.empty),
		.q_rdata  (q_rdata),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.spk      (spk),
		.out_last (out_last),
		.stat     (bk_stat)
	);

	assign spk_front_left  = spk[0];
	assign spk_front_right = spk[1];
	assign spk_rear_left   = spk[2];
	assign spk_rear_right  = spk[3];
	assign spk_center      = spk[4];
	assign spk_lfe         = spk[5];
	assign spk_side_left   = spk[6];
	assign spk_side_right  = spk[7];

	// sequencer only steps while the phase lies inside the current frame
	a_run_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.run |-> bk_stat.phase_in_frame)
		else $error("back end running with phase outside the frame");

	// a transaction leaves the queue only when the back end is idle and one is there
	a_pop_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (!q_stat.empty && !bk_stat.run))
		else $error("queue popped while empty or while back end busy");

	// queue occupancy stays within its depth
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= rvm_pkg::QCNT_W'(rvm_pkg::QUEUE_DEPTH))
		else $error("queue occupancy exceeds depth");

endmodule

`default_nettype wire

// ----- verif/rvm_mix_checker.sv -----
// Watches the register port and both streaming channels of the resampling voice mixer,
// predicts every output frame from the source frames and compares them in order.
// Depends on rvm_pkg for port widths, register indexes and mode bit positions.
`timescale 1ns / 1ps

module rvm_mix_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic                          pready,
	input  wire logic [rvm_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [rvm_pkg::DATA_W-1:0]    pwdata,
	input  wire logic                          in_valid,
	input  wire logic                          in_stall,
	input  wire logic signed [15:0]            src_left,
	input  wire logic signed [15:0]            src_right,
	input  wire logic                          out_valid,
	input  wire logic                          out_stall,
	input  wire logic signed [17:0]            spk_front_left,
	input  wire logic signed [17:0]            spk_front_right,
	input  wire logic signed [17:0]            spk_rear_left,
	input  wire logic signed [17:0]            spk_rear_right,
	input  wire logic signed [17:0]            spk_center,
	input  wire logic signed [17:0]            spk_lfe,
	input  wire logic signed [17:0]            spk_side_left,
	input  wire logic signed [17:0]            spk_side_right,
	input  wire logic                          out_last,
	output int                                 mismatches,
	output int                                 pending
);

	localparam int unsigned PHASE_ONE  = 32'h1_0000;
	localparam int unsigned STEP_FLOOR = PHASE_ONE >> rvm_pkg::STEP_MIN_SHIFT;
	localparam int          MAX_FRAMES = 64;
	localparam longint      PHASE_HALF = 64'sd32768;
	localparam longint      GAIN_HALF  = 64'sd1 <<< (rvm_pkg::GAIN_FRAC - 1);
	localparam longint      OUT_MAX    = 64'sd131071;
	localparam longint      OUT_MIN    = -64'sd131072;
	localparam int          SPK_FRONT_RIGHT = 1;
	localparam int          SPK_REAR_LEFT   = 2;
	localparam int          SPK_CENTER      = 4;
	localparam int          SPK_LFE         = 5;

	typedef struct packed {
		logic [rvm_pkg::SPK_PORTS-1:0][17:0] spk;
		logic                                last;
	} spk_frame_t;

	// register mirror
	logic [rvm_pkg::RATE_W-1:0]  rate_step_q;
	logic [rvm_pkg::START_W-1:0] start_phase_q;
	logic [rvm_pkg::MODE_W-1:0]  mix_mode_q;
	logic [rvm_pkg::GAINS_W-1:0] gains_front_q;
	logic [rvm_pkg::GAINS_W-1:0] gains_rear_q;

	// resampler state
	int unsigned        phase_acc;
	logic signed [15:0] prev_left;
	logic signed [15:0] prev_right;
	logic               primed;

	spk_frame_t expected_frames [$];
	spk_frame_t got_frame;
	spk_frame_t want_frame;

	string spk_names [0:7] = '{"spk_front_left", "spk_front_right", "spk_rear_left",
		"spk_rear_right", "spk_center", "spk_lfe", "spk_side_left", "spk_side_right"};

	// Interpolate and mix every output frame that one source frame yields.
	task automatic mix_source_frame(input logic signed [15:0] l_new,
			input logic signed [15:0] r_new);
		int unsigned        step;
		int                 n;
		longint             f, w0, sl, sr, avg, s, g;
		logic [63:0]        word;
		logic               stereo, surround, invert;
		spk_frame_t         fr;
		stereo   = mix_mode_q[rvm_pkg::MODE_STEREO];
		surround = mix_mode_q[rvm_pkg::MODE_SURROUND];
		invert   = mix_mode_q[rvm_pkg::MODE_INVERT];
		// first frame only primes the history
		if (!primed) begin
			prev_left  = l_new;
			prev_right = r_new;
			phase_acc  = start_phase_q;
			primed     = 1'b1;
			return;
		end
		step = rate_step_q;
		if (step < STEP_FLOOR)
			step = STEP_FLOOR;
		n = 0;
		while (phase_acc < PHASE_ONE && n < MAX_FRAMES) begin
			f   = longint'(phase_acc);
			w0  = longint'(PHASE_ONE) - f;
			sl  = (longint'(prev_left) * w0 + longint'(l_new) * f + PHASE_HALF) >>> 16;
			sr  = sl;
			avg = sl;
			if (stereo) begin
				sr  = (longint'(prev_right) * w0 + longint'(r_new) * f + PHASE_HALF) >>> 16;
				avg = (sl + sr) >>> 1;
			end
			for (int k = 0; k < rvm_pkg::SPK_PORTS; k++) begin
				if (k >= rvm_pkg::SPEAKERS_DEF || (k >= SPK_REAR_LEFT && !surround)) begin
					fr.spk[k] = '0;
				end else begin
					if (k == SPK_CENTER || k == SPK_LFE)
						s = avg;
					else if (k % 2 == 1)
						s = sr;
					else
						s = sl;
					word = (k < 4) ? gains_front_q : gains_rear_q;
					g = $signed(word[16*(k%4) +: 16]);
					if (k == SPK_FRONT_RIGHT && invert)
						g = -g;
					s = (s * g + GAIN_HALF) >>> rvm_pkg::GAIN_FRAC;
					if (s > OUT_MAX)
						s = OUT_MAX;
					else if (s < OUT_MIN)
						s = OUT_MIN;
					fr.spk[k] = s[17:0];
				end
			end
			phase_acc = phase_acc + step;
			n++;
			fr.last = !(phase_acc < PHASE_ONE && n < MAX_FRAMES);
			expected_frames.push_back(fr);
		end
		phase_acc  = phase_acc - PHASE_ONE;
		prev_left  = l_new;
		prev_right = r_new;
	endtask

	task automatic flag_mismatch(input string field, input logic signed [17:0] want_v,
			input logic signed [17:0] got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("mix check: %s expected %0d got %0d", field, want_v, got_v);
	endtask

	// Track register writes, predict on accepted source frames, compare output frames.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_step_q   = rvm_pkg::RATE_STEP_RST;
			start_phase_q = '0;
			mix_mode_q    = '0;
			gains_front_q = '0;
			gains_rear_q  = '0;
			phase_acc     = 0;
			prev_left     = '0;
			prev_right    = '0;
			primed        = 1'b0;
			mismatches    = 0;
			expected_frames.delete();
			pending       = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[rvm_pkg::ADDR_W-1:3])
					rvm_pkg::REG_RATE_STEP:   rate_step_q   = pwdata[rvm_pkg::RATE_W-1:0];
					rvm_pkg::REG_START_PHASE: start_phase_q = pwdata[rvm_pkg::START_W-1:0];
					rvm_pkg::REG_MIX_MODE:    mix_mode_q    = pwdata[rvm_pkg::MODE_W-1:0];
					rvm_pkg::REG_GAINS_FRONT: gains_front_q = pwdata;
					rvm_pkg::REG_GAINS_REAR:  gains_rear_q  = pwdata;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				mix_source_frame(src_left, src_right);
			if (out_valid && !out_stall) begin
				got_frame.spk = {spk_side_right, spk_side_left, spk_lfe, spk_center,
					spk_rear_right, spk_rear_left, spk_front_right, spk_front_left};
				got_frame.last = out_last;
				if (expected_frames.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mix check: output frame arrived with nothing expected");
				end else begin
					want_frame = expected_frames.pop_front();
					for (int k = 0; k < rvm_pkg::SPK_PORTS; k++)
						if (got_frame.spk[k] !== want_frame.spk[k])
							flag_mismatch(spk_names[k], want_frame.spk[k], got_frame.spk[k]);
					if (got_frame.last !== want_frame.last)
						flag_mismatch("out_last", want_frame.last, got_frame.last);
				end
			end
			pending = expected_frames.size();
		end
	end

endmodule

// ----- verif/tb_resampling_voice_mixer.sv -----
// Top of the resampling voice mixer testbench: clock, reset, register setup,
// bursty source frames and a stalling sink. Depends on rvm_pkg, the block and rvm_mix_checker.
`timescale 1ns / 1ps

module tb_resampling_voice_mixer;

	localparam logic [rvm_pkg::REG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
	localparam logic [rvm_pkg::REG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;
	localparam logic [63:0] M_STEREO   = 64'd1 << rvm_pkg::MODE_STEREO;
	localparam logic [63:0] M_SURROUND = 64'd1 << rvm_pkg::MODE_SURROUND;
	localparam logic [63:0] M_INVERT   = 64'd1 << rvm_pkg::MODE_INVERT;
	localparam int RANDOM_FRAMES = 460;
	localparam int SETTLE_CYCLES = 20;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_style_t;

	logic clk     = 1'b0;
	logic arst_n  = 1'b0;
	logic psel    = 1'b0;
	logic penable = 1'b0;
	logic pwrite  = 1'b0;
	logic [rvm_pkg::ADDR_W-1:0] paddr  = '0;
	logic [rvm_pkg::DATA_W-1:0] pwdata = '0;
	logic [rvm_pkg::DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] src_left  = '0;
	logic signed [15:0] src_right = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [17:0] spk_front_left, spk_front_right, spk_rear_left, spk_rear_right;
	logic signed [17:0] spk_center, spk_lfe, spk_side_left, spk_side_right;
	logic out_last;
	int mismatches;
	int pending;

	stall_style_t stall_style = STALL_NONE;
	int           stall_hold  = 0;
	logic [7:0]   stall_tick  = '0;

	always #1 clk = ~clk;

	resampling_voice_mixer u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .src_left(src_left), .src_right(src_right),
		.out_valid(out_valid), .out_stall(out_stall),
		.spk_front_left(spk_front_left), .spk_front_right(spk_front_right),
		.spk_rear_left(spk_rear_left), .spk_rear_right(spk_rear_right),
		.spk_center(spk_center), .spk_lfe(spk_lfe),
		.spk_side_left(spk_side_left), .spk_side_right(spk_side_right),
		.out_last(out_last)
	);

	rvm_mix_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_stall(in_stall), .src_left(src_left), .src_right(src_right),
		.out_valid(out_valid), .out_stall(out_stall),
		.spk_front_left(spk_front_left), .spk_front_right(spk_front_right),
		.spk_rear_left(spk_rear_left), .spk_rear_right(spk_rear_right),
		.spk_center(spk_center), .spk_lfe(spk_lfe),
		.spk_side_left(spk_side_left), .spk_side_right(spk_side_right),
		.out_last(out_last), .mismatches(mismatches), .pending(pending)
	);

	// Sink stall: switch between free, light, heavy and periodic stretches.
	always @(posedge clk) begin
		if (stall_hold == 0) begin
			stall_style <= stall_style_t'($urandom_range(0, 3));
			stall_hold  <= $urandom_range(16, 200);
		end else begin
			stall_hold <= stall_hold - 1;
		end
		case (stall_style)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:     out_stall <= stall_tick[2];
		endcase
		stall_tick <= stall_tick + 1'b1;
	end

	// Two-phase register write: setup, then access until pready.
	task automatic write_reg(input logic [rvm_pkg::REG_IDX_W-1:0] idx, input logic [63:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_mix(input logic [63:0] rate, input logic [63:0] start,
			input logic [63:0] mode, input logic [63:0] front, input logic [63:0] rear);
		write_reg(rvm_pkg::REG_RATE_STEP, rate);
		write_reg(rvm_pkg::REG_START_PHASE, start);
		write_reg(rvm_pkg::REG_MIX_MODE, mode);
		write_reg(rvm_pkg::REG_GAINS_FRONT, front);
		write_reg(rvm_pkg::REG_GAINS_REAR, rear);
	endtask

	// Present one source frame and hold it until the block takes it.
	task automatic send_frame(input logic [15:0] l, input logic [15:0] r);
		in_valid  <= 1'b1;
		src_left  <= l;
		src_right <= r;
		do @(posedge clk); while (in_stall);
	endtask

	// Hold off the sender until every predicted output frame has arrived.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	// Drain, then give frames that yield no output time to retire before reconfiguring.
	task automatic wait_idle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 15))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'h0000;
			3:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 7))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'h4000;
			3:       return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Random settings; junk above each field's width is left in the written word.
	task automatic random_setup(output int frames);
		logic [63:0] rate;
		rate = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0:       rate[17:0] = 18'($urandom_range(0, 1023));
			1:       rate[17:0] = 18'd262143;
			2:       rate[17:0] = 18'd1024;
			3:       rate[17:0] = 18'd65536;
			default: rate[17:0] = 18'($urandom_range(8192, 262143));
		endcase
		set_mix(rate, {$urandom, $urandom}, {$urandom, $urandom},
			{pick_gain(), pick_gain(), pick_gain(), pick_gain()},
			{pick_gain(), pick_gain(), pick_gain(), pick_gain()});
		frames = (rate[17:0] < 18'd4096) ? 12 : $urandom_range(40, 70);
	endtask

	// Send frames in bursts with random gaps and an occasional full drain.
	task automatic run_frames(input int count);
		int sent;
		int burst;
		int gap;
		sent = 0;
		gap  = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst && sent < count; b++) begin
				send_frame(pick_sample(), pick_sample());
				sent++;
			end
			if (sent < count) begin
				case ($urandom_range(0, 15))
					0:             wait_drained();
					1:             gap = $urandom_range(20, 40);
					2, 3, 4, 5, 6: gap = 0;
					default:       gap = $urandom_range(1, 6);
				endcase
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				gap = 0;
			end
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		int total;
		int frames;
		total = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Stereo surround at unity rate, half-frame start phase, extreme gains.
		set_mix(64'd65536, 64'h8000, M_STEREO | M_SURROUND,
			{16'hC000, 16'h4000, 16'h8000, 16'h7FFF},
			{16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF});
		send_frame(16'h7FFF, 16'h8000);
		send_frame(16'h8000, 16'h7FFF);
		send_frame(16'h0000, 16'h0000);
		send_frame(16'hFFFF, 16'h0001);
		send_frame(16'h7FFF, 16'h7FFF);
		send_frame(16'h8000, 16'h8000);
		wait_idle();

		// Rate below the floor: sixty-four frames per input, right gain negated.
		write_reg(rvm_pkg::REG_RATE_STEP, 64'd0);
		write_reg(rvm_pkg::REG_MIX_MODE, M_STEREO | M_SURROUND | M_INVERT);
		write_reg(REG_UNMAPPED_LO, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_UNMAPPED_HI, 64'h0000_0000_0000_0400);
		send_frame(16'h1234, 16'hABCD);
		send_frame(16'h8000, 16'h7FFF);
		wait_idle();

		// Largest rate, stereo without surround: most source frames are skipped.
		write_reg(rvm_pkg::REG_RATE_STEP, 64'd262143);
		write_reg(rvm_pkg::REG_MIX_MODE, M_STEREO);
		for (int i = 0; i < 6; i++)
			send_frame(pick_sample(), pick_sample());
		wait_idle();

		// Mono with junk above every field width.
		set_mix(64'hFFFF_FFFF_FFFC_9C40, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF8,
			64'h7FFF_8000_7FFF_8000, 64'h8000_7FFF_8000_7FFF);
		send_frame(16'h7FFF, 16'h8000);
		send_frame(16'h8000, 16'h0000);
		send_frame(16'hFFFF, 16'h7FFF);
		send_frame(16'h0001, 16'h8000);
		wait_idle();

		// Random settings, each followed by a random stretch of frames.
		while (total < RANDOM_FRAMES) begin
			random_setup(frames);
			run_frames(frames);
			total += frames;
			wait_idle();
		end

		if (mismatches == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Give up on a hang.
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

// ----- files.f -----
src/rvm_pkg.sv
src/rvm_front.sv
src/rvm_queue.sv
src/rvm_back.sv
src/resampling_voice_mixer.sv
verif/rvm_mix_checker.sv
verif/tb_resampling_voice_mixer.sv
